FILE: design/rkss_pkg.sv
// Package for the running k-th smallest store.
// Holds sizes, item and status codes, and the control struct broadcast to the cells.
`timescale 1ns / 1ps

package rkss_pkg;

  localparam int DEPTH       = 1024;
  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int GROUP       = 32;
  localparam int NGROUP      = (DEPTH + GROUP - 1) / GROUP;

  localparam int KIND_W   = 2;
  localparam int STATUS_W = 2;
  localparam int RESULT_W = 32;

  typedef logic signed [VALUE_WIDTH-1:0] val_t;
  typedef logic [CNT_W-1:0]              cnt_t;
  typedef logic [KIND_W-1:0]             kind_t;
  typedef logic [STATUS_W-1:0]           status_t;

  localparam kind_t KIND_ADD   = 2'd0;
  localparam kind_t KIND_GET   = 2'd1;
  localparam kind_t KIND_CLEAR = 2'd2;

  localparam status_t STATUS_OK    = 2'd0;
  localparam status_t STATUS_RANGE = 2'd1;
  localparam status_t STATUS_FULL  = 2'd2;

  typedef struct packed {
    logic ins;
    logic adv;
    logic clr;
    val_t v;
  } ctrl_t;

endpackage

FILE: design/running_kth_smallest_store.sv
// Top level of the running k-th smallest store: cell chain, rank counters, read tree.
// Depends on rkss_pkg and rkss_cell.
//
// Usage:
//   Input channel in_valid/in_ready carries in_kind and in_value. Kind add inserts
//   in_value at its sorted place (after equal values), kind get returns the value at
//   the running rank and advances it, kind clear empties the store and zeroes the
//   rank; kind 3 is ignored.
//   Output channel out_valid/out_ready carries out_result_value and out_status for
//   every get and for every add into a full store.
//   Throughput: one item per cycle of any kind while in_ready is high. An add shifts
//   the whole chain of cells at once; the rank mark steps one cell per get.
//   Result path: the value passes a registered two-level OR tree over the cells
//   (groups of 32), first into the group registers, then into the output register.
//   Reset (rst_n low, synchronous) empties the store and sets the rank to 0; no
//   clearing pass is needed.
//   When the receiver stalls, one result waits in the output register and one in
//   the tree stage; in_ready drops only once both are held.
`timescale 1ns / 1ps

module running_kth_smallest_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  rkss_pkg::kind_t              in_kind,
  input  logic signed [31:0]           in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           out_result_value,
  output rkss_pkg::status_t            out_status
);
  import rkss_pkg::*;

  localparam int NPAD = NGROUP * GROUP;

  cnt_t count_r, count_nxt;
  cnt_t rank_r, rank_nxt;
  ctrl_t ctrl;

  logic acc, is_add, is_get, is_clr, full, add_ok, get_ok, has_res;
  logic s1_v_r, s1_v_nxt, s1_adv;
  status_t s1_status_r;
  val_t grp_r [NGROUP];
  val_t grp_nxt [NGROUP];
  logic out_v_r, out_v_nxt;
  val_t out_value_r, out_value_nxt;
  status_t out_status_r;

  logic gt_w [DEPTH];
  val_t val_w [DEPTH];
  logic mark_w [DEPTH];
  val_t tap_w [NPAD];

  assign acc    = in_valid && in_ready;
  assign is_add = in_kind == KIND_ADD;
  assign is_get = in_kind == KIND_GET;
  assign is_clr = in_kind == KIND_CLEAR;
  assign full   = count_r == CNT_W'(DEPTH);
  assign add_ok = is_add && !full;
  assign get_ok = is_get && (rank_r < count_r);
  assign has_res = (is_add && full) || is_get;

  assign ctrl.ins = acc && add_ok;
  assign ctrl.adv = acc && get_ok;
  assign ctrl.clr = acc && is_clr;
  assign ctrl.v   = VALUE_WIDTH'(in_value);

  for (genvar i = 0; i < NPAD; i++) begin : g_cell
    if (i < DEPTH) begin : g_live
      if (i == 0) begin : g_head
        rkss_cell u_cell (
          .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .idx(CNT_W'(i)), .count(count_r),
          .prev_gt(1'b0), .prev_val('0), .prev_mark(1'b0),
          .gt(gt_w[i]), .val(val_w[i]), .mark(mark_w[i]), .tap(tap_w[i])
        );
      end else begin : g_body
        rkss_cell u_cell (
          .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .idx(CNT_W'(i)), .count(count_r),
          .prev_gt(gt_w[i-1]), .prev_val(val_w[i-1]), .prev_mark(mark_w[i-1]),
          .gt(gt_w[i]), .val(val_w[i]), .mark(mark_w[i]), .tap(tap_w[i])
        );
      end
    end else begin : g_pad
      assign tap_w[i] = '0;
    end
  end

  always_comb begin
    count_nxt = count_r;
    rank_nxt  = rank_r;
    if (ctrl.clr) begin
      count_nxt = '0;
      rank_nxt  = '0;
    end else begin
      if (ctrl.ins) begin
        count_nxt = count_r + 1'b1;
      end
      if (ctrl.adv) begin
        rank_nxt = rank_r + 1'b1;
      end
    end
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      grp_nxt[g] = '0;
      for (int j = 0; j < GROUP; j++) begin
        grp_nxt[g] = grp_nxt[g] | tap_w[g*GROUP + j];
      end
      if (!get_ok) begin
        grp_nxt[g] = '0;
      end
    end
  end

  assign s1_adv   = !out_v_r || out_ready;
  assign in_ready = !s1_v_r || s1_adv;

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    if (acc && has_res) begin
      s1_v_nxt = 1'b1;
    end
  end

  always_comb begin
    out_v_nxt = out_v_r;
    if (s1_adv) begin
      out_v_nxt = s1_v_r;
    end
    out_value_nxt = '0;
    for (int g = 0; g < NGROUP; g++) begin
      out_value_nxt = out_value_nxt | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rank_r  <= '0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      rank_r  <= rank_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && has_res) begin
      grp_r       <= grp_nxt;
      s1_status_r <= is_add ? STATUS_FULL : (get_ok ? STATUS_OK : STATUS_RANGE);
    end
    if (s1_adv && s1_v_r) begin
      out_value_r  <= out_value_nxt;
      out_status_r <= s1_status_r;
    end
  end

  assign out_valid        = out_v_r;
  assign out_result_value = RESULT_W'(out_value_r);
  assign out_status       = out_status_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rank_r <= count_r)
    else $error("rank beyond entry count");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && out_v_r && !out_ready) |-> !in_ready)
    else $error("item taken while both result stages are held");

  a_rank_step: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && get_ok) |=> (rank_r == $past(rank_r) + 1'b1))
    else $error("rank did not advance after a served get");

endmodule

FILE: design/rkss_cell.sv
// One cell of the sorted chain: a stored value and a rank mark.
// Depends on rkss_pkg for the value type and the broadcast control struct.
`timescale 1ns / 1ps

module rkss_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  rkss_pkg::ctrl_t ctrl,
  input  rkss_pkg::cnt_t  idx,
  input  rkss_pkg::cnt_t  count,
  input  logic           prev_gt,
  input  rkss_pkg::val_t  prev_val,
  input  logic           prev_mark,
  output logic           gt,
  output rkss_pkg::val_t  val,
  output logic           mark,
  output rkss_pkg::val_t  tap
);
  import rkss_pkg::*;

  val_t val_r, val_nxt;
  logic mark_r, mark_nxt;
  logic occ, tail;

  assign occ  = idx < count;
  assign tail = idx == count;
  assign gt   = occ && (val_r > ctrl.v);

  always_comb begin
    val_nxt = val_r;
    if (ctrl.ins && (occ || tail)) begin
      if (prev_gt) begin
        val_nxt = prev_val;
      end else if (gt || tail) begin
        val_nxt = ctrl.v;
      end
    end
  end

  always_comb begin
    mark_nxt = mark_r;
    if (ctrl.clr) begin
      mark_nxt = (idx == '0);
    end else if (ctrl.adv) begin
      mark_nxt = prev_mark;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= (idx == '0);
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign val  = val_r;
  assign mark = mark_r;
  assign tap  = mark_r ? val_r : '0;

endmodule

FILE: tb/sv/tb_running_kth_smallest_store.sv
// Testbench for running_kth_smallest_store: directed and random add/get/clear items.
// A scoreboard class tracks the sorted store and rank and checks every result.
// Depends on rkss_pkg and the running_kth_smallest_store RTL.
`timescale 1ns / 1ps

module tb_running_kth_smallest_store;
  import rkss_pkg::*;

  localparam kind_t KIND_IGNORED = 2'd3;
  localparam val_t  VAL_MAX      = 32'sh7fffffff;
  localparam val_t  VAL_MIN      = 32'sh80000000;
  localparam int    STALL_LIMIT  = 2000;
  localparam int    HOLD_CYCLES  = 100;
  localparam int    DRAIN_CYCLES = 8;

  class ranked_store_model;
    typedef struct {
      val_t    value;
      status_t status;
    } outcome_t;

    val_t     sorted_vals[DEPTH];
    int       stored;
    int       rank;
    outcome_t pending_results[$];
    int       errors;
    int       results_seen;

    function void note_item(kind_t kind, val_t value);
      int       pos;
      outcome_t o;
      case (kind)
        KIND_ADD: begin
          if (stored >= DEPTH) begin
            o.value  = '0;
            o.status = STATUS_FULL;
            pending_results.insert(pending_results.size(), o);
          end else begin
            pos = stored;
            while (pos > 0 && sorted_vals[pos-1] > value) begin
              sorted_vals[pos] = sorted_vals[pos-1];
              pos--;
            end
            sorted_vals[pos] = value;
            stored++;
          end
        end
        KIND_GET: begin
          if (rank >= stored) begin
            o.value  = '0;
            o.status = STATUS_RANGE;
          end else begin
            o.value  = sorted_vals[rank];
            o.status = STATUS_OK;
            rank++;
          end
          pending_results.insert(pending_results.size(), o);
        end
        KIND_CLEAR: begin
          stored = 0;
          rank   = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(val_t value, status_t status);
      outcome_t o;
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: result_value %0d status %0d", value, status);
        errors++;
      end else begin
        o = pending_results.pop_front();
        if (value !== o.value) begin
          $error("result_value: expected %0d, got %0d", o.value, value);
          errors++;
        end
        if (status !== o.status) begin
          $error("status: expected %0d, got %0d", o.status, status);
          errors++;
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst_n;
  logic    in_valid;
  logic    in_ready;
  kind_t   in_kind;
  val_t    in_value;
  logic    out_valid;
  logic    out_ready;
  val_t    out_result_value;
  status_t out_status;

  ranked_store_model sb;
  int                items_sent;
  bit                calm;

  running_kth_smallest_store dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kind          (in_kind),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_value (out_result_value),
    .out_status       (out_status)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_kind, in_value);
      if (out_valid && out_ready) sb.check_result(out_result_value, out_status);
    end
  end

  function automatic val_t random_value();
    int pick;
    pick = $urandom_range(99);
    if (pick < 60) return val_t'($urandom);
    if (pick < 85) return val_t'($signed($urandom_range(20)) - 10);
    case ($urandom_range(5))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return VAL_MIN + 1;
      3:       return VAL_MAX - 1;
      4:       return '0;
      default: return -1;
    endcase
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(kind_t kind, val_t value);
    calm = (items_sent >= 200 && items_sent < 360);
    while (!calm && $urandom_range(99) < 16) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic run_case(int adds, int gets, int add_pct);
    int adds_left;
    int gets_left;
    int pick;
    adds_left = adds;
    gets_left = gets;
    send_item(KIND_CLEAR, random_value());
    while (adds_left + gets_left > 0) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(KIND_IGNORED, random_value());
      end else if (adds_left > 0 && (gets_left == 0 || pick < add_pct)) begin
        send_item(KIND_ADD, random_value());
        adds_left--;
      end else begin
        send_item(KIND_GET, random_value());
        gets_left--;
      end
    end
  endtask

  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!hold_done && sb.results_seen >= 40) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= 16);
      end
    end
  end

  initial begin
    int stall_cycles;
    stall_cycles = 0;
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int adds;
    sb         = new();
    items_sent = 0;
    calm       = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_kind    = KIND_ADD;
    in_value   = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty store, extremes, duplicates, ignored kind, rank past count
    send_item(KIND_GET, VAL_MAX);
    send_item(KIND_ADD, VAL_MAX);
    send_item(KIND_ADD, VAL_MIN);
    send_item(KIND_ADD, '0);
    send_item(KIND_ADD, -1);
    send_item(KIND_ADD, 1);
    send_item(KIND_ADD, 5);
    send_item(KIND_ADD, 5);
    send_item(KIND_IGNORED, VAL_MIN);
    repeat (8) send_item(KIND_GET, '0);
    send_item(KIND_ADD, 2);
    send_item(KIND_GET, -1);
    send_item(KIND_GET, '0);
    send_item(KIND_CLEAR, -1);
    send_item(KIND_GET, '0);
    send_item(KIND_ADD, -7);
    send_item(KIND_GET, VAL_MAX);

    while (items_sent < 380) begin
      adds = $urandom_range(30);
      run_case(adds, adds + $urandom_range(3), 55);
    end
    // fill past capacity so adds get dropped
    run_case(DEPTH + 6, 90, 92);
    while (items_sent < 1550) begin
      adds = $urandom_range(30);
      run_case(adds, adds + $urandom_range(3), 55);
    end
    in_valid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
